>>> rtl/core/rfps_pkg.sv
// shared types and constants for the flight phase sequencer
`default_nettype none

package rfps_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_LAUNCH  = 3'd1,
        PH_FLIGHT  = 3'd2,
        PH_DESCENT = 3'd3,
        PH_LANDED  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        CMD_NOOP    = 3'd0,
        CMD_SAFE    = 3'd1,
        CMD_ABORT   = 3'd2,
        CMD_ARM     = 3'd3,
        CMD_TAKEOFF = 3'd4,
        CMD_DEPLOY  = 3'd5,
        CMD_CAMERAS = 3'd6,
        CMD_CLEAR   = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        REG_TAKEOFF_ALT = 2'd0,
        REG_DEPLOY_ALT  = 2'd1,
        REG_LAND_LIMIT  = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_idx_t;

    localparam int unsigned CFG_DATA_W = 15;
    localparam int unsigned COUNT_W    = 6;

    localparam logic [CFG_DATA_W-1:0] TAKEOFF_ALT_RST = 15'd100;
    localparam logic [CFG_DATA_W-1:0] DEPLOY_ALT_RST  = 15'd200;
    localparam logic [COUNT_W-1:0]    LAND_LIMIT_RST  = 6'd20;
    localparam logic [COUNT_W-1:0]    COUNT_MAX       = 6'd63;

    // pyro bit positions
    localparam int unsigned PB_CHUTE_ARM  = 0;
    localparam int unsigned PB_CHUTE_FIRE = 1;
    localparam int unsigned PB_CAM_ARM    = 2;
    localparam int unsigned PB_CAM_FIRE   = 3;

    // event bit positions
    localparam int unsigned EV_LIFTOFF = 0;
    localparam int unsigned EV_APOGEE  = 1;
    localparam int unsigned EV_LANDED  = 2;
    localparam int unsigned EV_CHUTE   = 3;

    typedef struct packed {
        logic               kind;
        logic [2:0]         command_code;
        logic               command_flag;
        logic               takeoff_seen_in;
        logic               apogee_seen_in;
        logic               landing_seen_in;
        logic signed [15:0] altitude;
        logic [15:0]        now_stamp;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic        chute_armed;
        logic        chute_fired;
        logic        camera_armed;
        logic        camera_fired;
        logic        liftoff_flag;
        logic        apogee_flag;
        logic        landed_flag;
        logic        chute_event_flag;
        logic [15:0] liftoff_stamp;
        logic [15:0] deploy_stamp;
    } out_word_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] takeoff_altitude;
        logic [CFG_DATA_W-1:0] deploy_altitude;
        logic [COUNT_W-1:0]    landing_count_limit;
    } cfg_t;

    typedef struct packed {
        phase_t             phase;
        logic [3:0]         pyro;
        logic [3:0]         events;
        logic               high_mark;
        logic [COUNT_W-1:0] landing_count;
        logic [15:0]        liftoff_time;
        logic [15:0]        deploy_time;
    } fl_state_t;

endpackage

`default_nettype wire

>>> rtl/core/rocket_flight_phase_sequencer_top.sv
// top level of the rocket flight phase sequencer
// path: each word passes the input register, then the result register; a full result slot
//   that is not being drained holds the word in the input register
// throughput: one word per cycle while m_ready holds, state updates in the same cycle the result is captured
// the feedback loop is the phase/state register through the step logic
// reset: aresetn synchronous active low; phase idle, pyro, events, mark, count, stamps zero, valids clear
`default_nettype none

module rocket_flight_phase_sequencer_top
    import rfps_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    // input words: sensor ticks and ground commands
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_word_t              s_data,

    // result words: state after each input word
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_word_t                  m_data
);

    // config registers come out of reset at 100, 200 and 20
    cfg_t      cfg;

    // input register stage
    logic      in_valid_reg;
    logic      in_valid_next;
    in_word_t  in_word_reg;

    // flight state
    fl_state_t st_reg;
    fl_state_t st_step;

    // result register stage
    logic      out_valid_reg;
    logic      out_valid_next;
    out_word_t out_word_reg;
    out_word_t out_word_next;

    logic      s_fire;
    logic      advance;

    rfps_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rfps_step u_step (
        .word_in (in_word_reg),
        .cfg     (cfg),
        .st      (st_reg),
        .st_next (st_step)
    );

    // the held word moves on when the result slot is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // result word shows the state after the word
    always_comb begin
        out_word_next.phase            = st_step.phase;
        out_word_next.chute_armed      = st_step.pyro[PB_CHUTE_ARM];
        out_word_next.chute_fired      = st_step.pyro[PB_CHUTE_FIRE];
        out_word_next.camera_armed     = st_step.pyro[PB_CAM_ARM];
        out_word_next.camera_fired     = st_step.pyro[PB_CAM_FIRE];
        out_word_next.liftoff_flag     = st_step.events[EV_LIFTOFF];
        out_word_next.apogee_flag      = st_step.events[EV_APOGEE];
        out_word_next.landed_flag      = st_step.events[EV_LANDED];
        out_word_next.chute_event_flag = st_step.events[EV_CHUTE];
        out_word_next.liftoff_stamp    = st_step.liftoff_time;
        out_word_next.deploy_stamp     = st_step.deploy_time;
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '{phase: PH_IDLE, default: '0};
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                st_reg <= st_step;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_word_reg <= s_data;
        end
        if (advance) begin
            out_word_reg <= out_word_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

endmodule

`default_nettype wire

>>> rtl/core/rfps_cfg.sv
// configuration register file for the flight phase sequencer
`default_nettype none

module rfps_cfg
    import rfps_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_index))
                REG_TAKEOFF_ALT: cfg_next.takeoff_altitude    = cfg_wdata;
                REG_DEPLOY_ALT:  cfg_next.deploy_altitude     = cfg_wdata;
                REG_LAND_LIMIT:  cfg_next.landing_count_limit = cfg_wdata[COUNT_W-1:0];
                REG_UNUSED:      cfg_next = cfg_reg;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.takeoff_altitude    <= TAKEOFF_ALT_RST;
            cfg_reg.deploy_altitude     <= DEPLOY_ALT_RST;
            cfg_reg.landing_count_limit <= LAND_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/core/rfps_step.sv
// next-state logic for one word: phase transitions, descent mark and count, pyro, events, stamps
`default_nettype none

module rfps_step
    import rfps_pkg::*;
(
    input  wire in_word_t  word_in,
    input  wire cfg_t      cfg,
    input  wire fl_state_t st,
    output fl_state_t      st_next
);

    logic               is_tick;
    logic               is_cmd;
    cmd_t               cmd;
    logic signed [15:0] to_alt_s;
    logic signed [15:0] dep_alt_s;
    logic               tick_descent;
    logic               go_idle;
    logic               go_launch;
    logic               go_flight;
    logic               go_descent;
    logic               go_landed;
    logic               mark_next;
    logic [COUNT_W-1:0] count_next;
    phase_t             phase_next;

    assign is_tick   = !word_in.kind;
    assign is_cmd    = word_in.kind;
    assign cmd       = cmd_t'(word_in.command_code);
    assign to_alt_s  = $signed({1'b0, cfg.takeoff_altitude});
    assign dep_alt_s = $signed({1'b0, cfg.deploy_altitude});

    assign tick_descent = is_tick && (st.phase == PH_DESCENT);

    // descent: high mark latches, then consecutive low landings are counted
    always_comb begin
        mark_next  = st.high_mark | (tick_descent && (word_in.altitude > dep_alt_s));
        count_next = st.landing_count;
        if (tick_descent && mark_next) begin
            if (word_in.landing_seen_in && (word_in.altitude < dep_alt_s)) begin
                if (st.landing_count != COUNT_MAX) begin
                    count_next = st.landing_count + 1'b1;
                end
            end else begin
                count_next = '0;
            end
        end
    end

    assign go_idle    = is_cmd && ((cmd == CMD_ABORT) ||
                                   ((cmd == CMD_TAKEOFF) && !word_in.command_flag));
    assign go_launch  = is_cmd && (cmd == CMD_TAKEOFF) && word_in.command_flag;
    assign go_flight  = is_tick && (st.phase == PH_LAUNCH) &&
                        (word_in.takeoff_seen_in || (word_in.altitude > to_alt_s));
    assign go_descent = is_tick && (st.phase == PH_FLIGHT) && word_in.apogee_seen_in;
    assign go_landed  = tick_descent && mark_next &&
                        (count_next > cfg.landing_count_limit);

    // phase next state
    always_comb begin
        priority if (go_idle) begin
            phase_next = PH_IDLE;
        end else if (go_launch) begin
            phase_next = PH_LAUNCH;
        end else if (go_flight) begin
            phase_next = PH_FLIGHT;
        end else if (go_descent) begin
            phase_next = PH_DESCENT;
        end else if (go_landed) begin
            phase_next = PH_LANDED;
        end else begin
            phase_next = st.phase;
        end
    end

    // pyro, events and stamps
    always_comb begin
        st_next               = st;
        st_next.phase         = phase_next;
        st_next.high_mark     = mark_next;
        st_next.landing_count = count_next;

        if (is_cmd) begin
            unique case (cmd)
                CMD_NOOP: begin
                end
                CMD_SAFE, CMD_ABORT: begin
                    st_next.pyro[PB_CHUTE_ARM]  = 1'b0;
                    st_next.pyro[PB_CHUTE_FIRE] = 1'b0;
                end
                CMD_ARM: begin
                    st_next.pyro[PB_CHUTE_ARM] = 1'b1;
                end
                CMD_TAKEOFF: begin
                    if (!word_in.command_flag) begin
                        st_next.pyro[PB_CHUTE_ARM]  = 1'b0;
                        st_next.pyro[PB_CHUTE_FIRE] = 1'b0;
                    end
                end
                CMD_DEPLOY: begin
                    st_next.pyro[PB_CHUTE_FIRE] = 1'b1;
                    st_next.events[EV_CHUTE]    = 1'b1;
                end
                CMD_CAMERAS: begin
                    st_next.pyro[PB_CAM_ARM]  = word_in.command_flag;
                    st_next.pyro[PB_CAM_FIRE] = word_in.command_flag;
                end
                CMD_CLEAR: begin
                    if (st.phase == PH_IDLE) begin
                        st_next.events       = '0;
                        st_next.liftoff_time = '0;
                        st_next.deploy_time  = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        if (go_flight) begin
            st_next.events[EV_LIFTOFF] = 1'b1;
            st_next.liftoff_time       = word_in.now_stamp;
        end
        if (go_descent) begin
            st_next.events[EV_APOGEE]   = 1'b1;
            st_next.events[EV_CHUTE]    = 1'b1;
            st_next.pyro[PB_CHUTE_FIRE] = 1'b1;
            st_next.pyro[PB_CAM_FIRE]   = 1'b1;
            st_next.deploy_time         = word_in.now_stamp;
        end
        if (go_landed) begin
            st_next.events[EV_LANDED] = 1'b1;
        end
    end

endmodule

`default_nettype wire
